### src/gbwf_pkg.sv
package gbwf_pkg;

  // Element kind codes
  localparam logic [1:0] KIND_POINT  = 2'd0;
  localparam logic [1:0] KIND_VECTOR = 2'd1;
  localparam logic [1:0] KIND_LINE   = 2'd2;

  // One input element
  typedef struct packed {
    logic [1:0]         kind;
    logic               active;
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic signed [31:0] third_value;
    logic signed [31:0] fourth_value;
    logic               last_element;
  } in_item_t;

  // One fitted window
  typedef struct packed {
    logic signed [31:0] window_x_low;
    logic signed [31:0] window_x_high;
    logic signed [31:0] window_y_low;
    logic signed [31:0] window_y_high;
    logic               used_default;
  } out_item_t;

  // Which candidate point goes into the box this cycle
  typedef enum logic [2:0] {
    CAND_NONE,
    CAND_POINT,
    CAND_ORIGIN,
    CAND_TIP,
    CAND_ZERO,
    CAND_Y_QUOT,
    CAND_X_QUOT
  } cand_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic      capture;
    cand_sel_t cand;
    logic      div_start;
    logic      div_by_a;
    logic      pad_clamp;
    logic      pad_extent;
    logic      emit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] kind;
    logic       active;
    logic       last;
    logic       a_zero;
    logic       b_zero;
    logic       div_done;
    logic       out_free;
  } dp_sts_t;

endpackage

### src/gbwf_div.sv
// Bit-serial restoring divider: quot = sat32(-(num * 2^FRAC_BITS) / den),
// truncated toward zero. One quotient bit per cycle, then a saturate step.
module gbwf_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quot
);

  localparam int DW = 32 + FRAC_BITS;
  localparam int CW = $clog2(DW);

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_SAT
  } dv_state_t;

  dv_state_t          state_r;
  logic [CW-1:0]      cnt_r;
  logic [31:0]        rem_r;
  logic [DW-1:0]      dvd_r;
  logic [31:0]        den_r;
  logic               neg_r;
  logic               done_r;
  logic signed [31:0] quot_r;

  logic [31:0] num_mag;
  logic [31:0] den_mag;
  logic [32:0] shifted;
  logic [33:0] diff;
  logic        qbit;
  logic        hi_nz;
  logic        over;
  logic [31:0] sat_val;

  // Operand magnitudes; the result is negative when num and den share a sign
  assign num_mag = num[31] ? 32'(-num) : 32'(num);
  assign den_mag = den[31] ? 32'(-den) : 32'(den);

  // Trial subtract
  assign shifted = {rem_r, dvd_r[DW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_r};
  assign qbit    = ~diff[33];

  // Saturation of the quotient magnitude
  assign hi_nz = |dvd_r[DW-1:32];
  always_comb begin
    if (neg_r) begin
      over    = hi_nz || (dvd_r[31] && (|dvd_r[30:0]));
      sat_val = over ? 32'h8000_0000 : 32'(-dvd_r[31:0]);
    end else begin
      over    = hi_nz || dvd_r[31];
      sat_val = over ? 32'h7FFF_FFFF : dvd_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        DV_IDLE: begin
          if (start) begin
            rem_r   <= '0;
            dvd_r   <= {num_mag, {FRAC_BITS{1'b0}}};
            den_r   <= den_mag;
            neg_r   <= ~(num[31] ^ den[31]);
            cnt_r   <= CW'(DW - 1);
            state_r <= DV_RUN;
          end
        end
        DV_RUN: begin
          rem_r <= qbit ? diff[31:0] : shifted[31:0];
          dvd_r <= {dvd_r[DW-2:0], qbit};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= DV_SAT;
          end
        end
        DV_SAT: begin
          quot_r  <= sat_val;
          done_r  <= 1'b1;
          state_r <= DV_IDLE;
        end
        default: state_r <= DV_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

### src/gbwf_dp.sv
// Datapath: item register, running box, divider, padding and output register.
module gbwf_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gbwf_pkg::dp_cmd_t   cmd,
  output gbwf_pkg::dp_sts_t   sts,
  input  gbwf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gbwf_pkg::out_item_t out_data
);

  localparam logic [31:0] TWO_FX = 32'(64'd2 << FRAC_BITS);
  localparam logic [31:0] DEF_X  = 32'(64'd10 << FRAC_BITS);
  localparam logic [31:0] DEF_Y  = 32'(64'd25 << (FRAC_BITS - 2));

  function automatic logic [31:0] sat32(input logic [34:0] v);
    logic [31:0] r;
    if ((v[34:31] == 4'b0000) || (v[34:31] == 4'b1111)) begin
      r = v[31:0];
    end else begin
      r = v[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  gbwf_pkg::in_item_t  item_r;
  gbwf_pkg::out_item_t out_r;
  logic                out_valid_r;
  logic signed [31:0]  tip_x_r, tip_y_r;
  logic                seen_r, only_lines_r;
  logic signed [31:0]  bxl_r, bxh_r, byl_r, byh_r;
  logic signed [31:0]  cxl_r, cxh_r, cyl_r, cyh_r;
  logic [32:0]         ext_x_r, ext_y_r;
  logic [31:0]         pad_x_r, pad_y_r;

  logic signed [31:0]  cand_x, cand_y;
  logic signed [31:0]  quot;
  logic                div_done;
  logic signed [31:0]  cxl, cxh, cyl, cyh;
  logic [31:0]         tip_x, tip_y;

  // Serial divider for the line intercepts
  gbwf_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.div_start),
    .num  (item_r.third_value),
    .den  (cmd.div_by_a ? item_r.first_value : item_r.second_value),
    .done (div_done),
    .quot (quot)
  );

  // Vector tip, saturated per axis
  assign tip_x = sat32({{3{in_data.third_value[31]}}, in_data.third_value}
                     + {{3{in_data.first_value[31]}}, in_data.first_value});
  assign tip_y = sat32({{3{in_data.fourth_value[31]}}, in_data.fourth_value}
                     + {{3{in_data.second_value[31]}}, in_data.second_value});

  // Candidate select
  always_comb begin
    unique case (cmd.cand)
      gbwf_pkg::CAND_POINT: begin
        cand_x = item_r.first_value;
        cand_y = item_r.second_value;
      end
      gbwf_pkg::CAND_ORIGIN: begin
        cand_x = item_r.third_value;
        cand_y = item_r.fourth_value;
      end
      gbwf_pkg::CAND_TIP: begin
        cand_x = tip_x_r;
        cand_y = tip_y_r;
      end
      gbwf_pkg::CAND_Y_QUOT: begin
        cand_x = '0;
        cand_y = quot;
      end
      gbwf_pkg::CAND_X_QUOT: begin
        cand_x = quot;
        cand_y = '0;
      end
      default: begin
        cand_x = '0;
        cand_y = '0;
      end
    endcase
  end

  // Lines alone: pull the box over the origin
  assign cxl = (only_lines_r && !bxl_r[31]) ? '0 : bxl_r;
  assign cxh = (only_lines_r &&  bxh_r[31]) ? '0 : bxh_r;
  assign cyl = (only_lines_r && !byl_r[31]) ? '0 : byl_r;
  assign cyh = (only_lines_r &&  byh_r[31]) ? '0 : byh_r;

  // Set state: seen flag, lines-only flag, running box
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r       <= 1'b0;
      only_lines_r <= 1'b1;
      bxl_r        <= '0;
      bxh_r        <= '0;
      byl_r        <= '0;
      byh_r        <= '0;
    end else if (cmd.emit) begin
      seen_r       <= 1'b0;
      only_lines_r <= 1'b1;
      bxl_r        <= '0;
      bxh_r        <= '0;
      byl_r        <= '0;
      byh_r        <= '0;
    end else begin
      if (cmd.capture && in_data.active && (in_data.kind != gbwf_pkg::KIND_LINE)) begin
        only_lines_r <= 1'b0;
      end
      if (cmd.cand != gbwf_pkg::CAND_NONE) begin
        seen_r <= 1'b1;
        if (!seen_r) begin
          bxl_r <= cand_x;
          bxh_r <= cand_x;
          byl_r <= cand_y;
          byh_r <= cand_y;
        end else begin
          if (cand_x < bxl_r) bxl_r <= cand_x;
          if (cand_x > bxh_r) bxh_r <= cand_x;
          if (cand_y < byl_r) byl_r <= cand_y;
          if (cand_y > byh_r) byh_r <= cand_y;
        end
      end
    end
  end

  // Item capture and padding pipeline
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r  <= in_data;
      tip_x_r <= tip_x;
      tip_y_r <= tip_y;
    end
    if (cmd.pad_clamp) begin
      cxl_r   <= cxl;
      cxh_r   <= cxh;
      cyl_r   <= cyl;
      cyh_r   <= cyh;
      ext_x_r <= {cxh[31], cxh} - {cxl[31], cxl};
      ext_y_r <= {cyh[31], cyh} - {cyl[31], cyl};
    end
    if (cmd.pad_extent) begin
      pad_x_r <= {1'b0, ext_x_r[32:2]} + TWO_FX;
      pad_y_r <= {1'b0, ext_y_r[32:2]} + TWO_FX;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (seen_r) begin
        out_r.window_x_low  <= sat32({{3{cxl_r[31]}}, cxl_r} - {3'b000, pad_x_r});
        out_r.window_x_high <= sat32({{3{cxh_r[31]}}, cxh_r} + {3'b000, pad_x_r});
        out_r.window_y_low  <= sat32({{3{cyl_r[31]}}, cyl_r} - {3'b000, pad_y_r});
        out_r.window_y_high <= sat32({{3{cyh_r[31]}}, cyh_r} + {3'b000, pad_y_r});
        out_r.used_default  <= 1'b0;
      end else begin
        out_r.window_x_low  <= -DEF_X;
        out_r.window_x_high <= DEF_X;
        out_r.window_y_low  <= -DEF_Y;
        out_r.window_y_high <= DEF_Y;
        out_r.used_default  <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Status
  assign sts.kind     = item_r.kind;
  assign sts.active   = item_r.active;
  assign sts.last     = item_r.last_element;
  assign sts.a_zero   = (item_r.first_value == '0);
  assign sts.b_zero   = (item_r.second_value == '0);
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || !out_stall;

endmodule

### src/gbwf_ctrl.sv
// Controller: walks one element through its candidates, then pads and emits.
module gbwf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gbwf_pkg::dp_sts_t sts,
  output gbwf_pkg::dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_POINT,
    ST_ORIGIN,
    ST_TIP,
    ST_ZERO,
    ST_DIVB_GO,
    ST_DIVB_WAIT,
    ST_YQ,
    ST_DIVA_GO,
    ST_DIVA_WAIT,
    ST_XQ,
    ST_FINISH,
    ST_PAD_CLAMP,
    ST_PAD_EXT,
    ST_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        if (!sts.active) begin
          state_nxt = ST_FINISH;
        end else begin
          unique case (sts.kind)
            gbwf_pkg::KIND_POINT:  state_nxt = ST_POINT;
            gbwf_pkg::KIND_VECTOR: state_nxt = ST_ORIGIN;
            gbwf_pkg::KIND_LINE:   state_nxt = ST_ZERO;
            default:               state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_POINT:     state_nxt = ST_FINISH;
      ST_ORIGIN:    state_nxt = ST_TIP;
      ST_TIP:       state_nxt = ST_FINISH;
      ST_ZERO: begin
        priority if (!sts.b_zero) state_nxt = ST_DIVB_GO;
        else if (!sts.a_zero)     state_nxt = ST_DIVA_GO;
        else                      state_nxt = ST_FINISH;
      end
      ST_DIVB_GO:   state_nxt = ST_DIVB_WAIT;
      ST_DIVB_WAIT: if (sts.div_done) state_nxt = ST_YQ;
      ST_YQ:        state_nxt = sts.a_zero ? ST_FINISH : ST_DIVA_GO;
      ST_DIVA_GO:   state_nxt = ST_DIVA_WAIT;
      ST_DIVA_WAIT: if (sts.div_done) state_nxt = ST_XQ;
      ST_XQ:        state_nxt = ST_FINISH;
      ST_FINISH:    state_nxt = sts.last ? ST_PAD_CLAMP : ST_IDLE;
      ST_PAD_CLAMP: state_nxt = ST_PAD_EXT;
      ST_PAD_EXT:   state_nxt = ST_EMIT;
      ST_EMIT:      if (sts.out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Command decode
  always_comb begin
    cmd            = '0;
    cmd.cand       = gbwf_pkg::CAND_NONE;
    cmd.capture    = (state_r == ST_IDLE) && in_valid;
    cmd.div_start  = (state_r == ST_DIVB_GO) || (state_r == ST_DIVA_GO);
    cmd.div_by_a   = (state_r == ST_DIVA_GO);
    cmd.pad_clamp  = (state_r == ST_PAD_CLAMP);
    cmd.pad_extent = (state_r == ST_PAD_EXT);
    cmd.emit       = (state_r == ST_EMIT) && sts.out_free;
    unique case (state_r)
      ST_POINT:  cmd.cand = gbwf_pkg::CAND_POINT;
      ST_ORIGIN: cmd.cand = gbwf_pkg::CAND_ORIGIN;
      ST_TIP:    cmd.cand = gbwf_pkg::CAND_TIP;
      ST_ZERO:   cmd.cand = gbwf_pkg::CAND_ZERO;
      ST_YQ:     cmd.cand = gbwf_pkg::CAND_Y_QUOT;
      ST_XQ:     cmd.cand = gbwf_pkg::CAND_X_QUOT;
      default:   cmd.cand = gbwf_pkg::CAND_NONE;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

### src/geometry_bounding_window_fit.sv
// Bounding window fit: takes one element (point, vector or line) per transfer
// and grows an axis-aligned box over its candidate points; the element marked
// last releases a padded window (or the default window when nothing was seen).
// Items are handled one at a time. A point adds itself to the box, a vector
// its origin and tip, and a line the point (0,0) plus one point per intercept
// it has, each intercept from the bit-serial divider that yields one quotient
// bit per cycle (in Q16.16 with the default FRAC_BITS). A last element then
// clamps and pads the box and loads the output register; a new item is
// accepted while a finished window still waits in that register.
module geometry_bounding_window_fit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gbwf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gbwf_pkg::out_item_t out_data
);

  gbwf_pkg::dp_cmd_t cmd;
  gbwf_pkg::dp_sts_t sts;

  gbwf_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  gbwf_dp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
